[src/c2p_pkg.sv]
// ----------------------------------------------------------------------------
// c2p_pkg
// Types, constants and the row-to-band table used by the chunky to planar
// converter; the remap table memory does not import it.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int BANDS        = 10;
    localparam int SCREEN_LINES = 200;
    localparam int MAX_WIDTH    = 128;
    localparam int DEPTH        = 4;

    localparam int PLANES     = 4;
    localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int TBL_WORDS  = BANDS * 256;
    localparam int TBL_ADDR_W = BAND_W + 8;
    localparam logic [7:0] LEFT_BIT = 8'h80;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_PIXEL       = 1'b1
    } t_op;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel;
        logic [7:0] row;
        logic       last_in_row;
        logic [3:0] table_band;
        logic [7:0] table_index;
        logic [3:0] table_slot;
    } t_in;

    typedef struct packed {
        logic [7:0] plane0;
        logic [7:0] plane1;
        logic [7:0] plane2;
        logic [7:0] plane3;
        logic [3:0] byte_index;
        logic       row_end;
    } t_out;

    typedef logic [255:0][BAND_W-1:0] t_band_lut;

    function automatic t_band_lut build_band_lut();
        t_band_lut lut;
        int        b;
        for (int r = 0; r < 256; r++) begin
            b = (r * BANDS) / SCREEN_LINES;
            if (b >= BANDS) begin
                b = BANDS - 1;
            end
            lut[r] = BAND_W'(b);
        end
        return lut;
    endfunction

    localparam t_band_lut BAND_LUT = build_band_lut();

endpackage

[src/c2p_ram.sv]
// ----------------------------------------------------------------------------
// c2p_ram
// Generic simple dual port RAM, one write port and one registered read port
// with read enable.
// ----------------------------------------------------------------------------
module c2p_ram #(
    parameter int DATA_W = 4,
    parameter int WORDS  = 2560
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(WORDS)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/chunky_to_planar_remap.sv]
// ----------------------------------------------------------------------------
// chunky_to_planar_remap
// Converts a stream of chunky colour indices into four bitplane bytes,
// remapping each index through a per-band palette slot table.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid, i_in_data, o_in_stall): table writes (op 0) load
// one remap entry of a band, pixel items (op 1) carry index, row and an end
// of row flag. Output channel (o_out_valid, o_out_data, i_out_stall): one
// transfer per finished byte group of four plane bytes with its byte index.
// Throughput is one item per clock while o_in_stall is low. A pixel that closes
// a byte group (eighth pixel, last pixel of the row, or last column of the line
// buffer) shows its result after the registered remap table read and then the
// bit insert into the output register; a receiver stall may hold it in between.
// Reset clears the column count, the pending plane bits and both valid
// stages; remap table contents are undefined until written.
// While the receiver stalls, the output register holds, the pixel waiting in
// the read stage holds if it closes a group, and o_in_stall rises; items that
// do not close a group keep flowing into the pending plane bits.
// ----------------------------------------------------------------------------
module chunky_to_planar_remap (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  c2p_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output c2p_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    logic                               in_xfer;
    logic                               tbl_we;
    logic [c2p_pkg::TBL_ADDR_W-1:0]     tbl_waddr;
    logic                               tbl_re;
    logic [c2p_pkg::TBL_ADDR_W-1:0]     tbl_raddr;
    logic [3:0]                         tbl_slot;
    logic [c2p_pkg::BAND_W-1:0]         rd_band;

    logic                               r_s1_valid;
    logic                               r_s1_last;
    logic [c2p_pkg::COL_W-1:0]          r_col;
    logic [c2p_pkg::COL_W-1:0]          n_col;
    logic [c2p_pkg::PLANES-1:0][7:0]    r_planes;
    logic [c2p_pkg::PLANES-1:0][7:0]    n_planes;
    logic [c2p_pkg::PLANES-1:0][7:0]    ins_planes;
    logic                               r_out_valid;
    logic                               n_out_valid;
    c2p_pkg::t_out                      r_out;
    c2p_pkg::t_out                      n_out;

    logic                               out_free;
    logic                               col_at_end;
    logic                               s1_flush;
    logic                               s1_adv;
    logic [7:0]                         bit_mask;

    // remap table write and read
    assign in_xfer   = i_in_valid && !o_in_stall;
    assign tbl_we    = in_xfer && (i_in_data.op == c2p_pkg::OP_TABLE_WRITE)
                       && (32'(i_in_data.table_band) < 32'(c2p_pkg::BANDS));
    assign tbl_waddr = {c2p_pkg::BAND_W'(i_in_data.table_band), i_in_data.table_index};
    assign rd_band   = c2p_pkg::BAND_LUT[i_in_data.row];
    assign tbl_re    = in_xfer && (i_in_data.op == c2p_pkg::OP_PIXEL);
    assign tbl_raddr = {rd_band, i_in_data.pixel};

    c2p_ram #(
        .DATA_W (4),
        .WORDS  (c2p_pkg::TBL_WORDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_in_data.table_slot),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_slot)
    );

    // bit insert and flush
    assign out_free   = !r_out_valid || !i_out_stall;
    assign col_at_end = (r_col == c2p_pkg::COL_W'(c2p_pkg::MAX_WIDTH - 1));
    assign s1_flush   = (r_col[2:0] == 3'd7) || r_s1_last || col_at_end;
    assign s1_adv     = r_s1_valid && (!s1_flush || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign bit_mask   = c2p_pkg::LEFT_BIT >> r_col[2:0];

    always_comb begin
        for (int p = 0; p < c2p_pkg::PLANES; p++) begin
            ins_planes[p] = r_planes[p];
            if (p < c2p_pkg::DEPTH && tbl_slot[p]) begin
                ins_planes[p] = r_planes[p] | bit_mask;
            end
        end
    end

    always_comb begin
        n_col       = r_col;
        n_planes    = r_planes;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (s1_adv) begin
            if (s1_flush) begin
                n_planes         = '0;
                n_out.plane0     = ins_planes[0];
                n_out.plane1     = ins_planes[1];
                n_out.plane2     = ins_planes[2];
                n_out.plane3     = ins_planes[3];
                n_out.byte_index = 4'(r_col >> 3);
                n_out.row_end    = r_s1_last;
                n_out_valid      = 1'b1;
                if (r_s1_last || col_at_end) begin
                    n_col = '0;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end else begin
                n_planes = ins_planes;
                n_col    = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_planes    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= tbl_re;
            end
            r_out_valid <= n_out_valid;
            r_col       <= n_col;
            r_planes    <= n_planes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_last <= i_in_data.last_in_row;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
